[rtl/lst_pkg.sv]
// Shared types and constants for the line sensor track step block.
// No dependencies; imported by line_sensor_track_step_core.
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

  // Input word: one command plus a five-sensor sample.
  typedef struct packed {
    logic       command;
    logic [4:0] sensors;
  } sample_t;

  // Result word.
  typedef struct packed {
    logic signed [3:0] bearing;
    logic [1:0]        turn_request;
    logic              running;
    logic              stop_event;
    logic [7:0]        crossings_seen;
  } result_t;

  // Command codes
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSS_TARGET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOST_LIMIT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSS_GAP    = 2'd2;

  // Configuration reset values
  localparam logic [7:0] CROSS_TARGET_RST = 8'd4;
  localparam logic [7:0] LOST_LIMIT_RST   = 8'd50;
  localparam logic [5:0] CROSS_GAP_RST    = 6'd50;

  // Turn request codes
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // Sensor masks
  localparam logic [4:0] SENS_NONE        = 5'h00;
  localparam logic [4:0] SENS_OUTER_MASK  = 5'h11;
  localparam logic [4:0] SENS_OUTER_LEFT  = 5'h10;
  localparam logic [4:0] SENS_OUTER_RIGHT = 5'h01;
  localparam logic [4:0] SENS_MIDDLE      = 5'h04;
  localparam logic [4:0] SENS_ALL         = 5'h1F;

  // Sensor patterns that set a bearing
  localparam logic [4:0] PAT_CENTER     = 5'h04;
  localparam logic [4:0] PAT_MID_LEFT   = 5'h0C;
  localparam logic [4:0] PAT_MID_RIGHT  = 5'h06;
  localparam logic [4:0] PAT_LEFT       = 5'h08;
  localparam logic [4:0] PAT_RIGHT      = 5'h02;
  localparam logic [4:0] PAT_WIDE_LEFT  = 5'h18;
  localparam logic [4:0] PAT_WIDE_RIGHT = 5'h03;
  localparam logic [4:0] PAT_EDGE_LEFT  = 5'h10;
  localparam logic [4:0] PAT_EDGE_RIGHT = 5'h01;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

endpackage : lst_pkg

`default_nettype wire

[rtl/line_sensor_track_step_core.sv]
// Five-sensor line follower step: mode, bearing, corner and crossing logic.
// Depends on lst_pkg (word types, codes, sensor patterns).
// A result word is registered into the result register, or into the skid register
// while the result register is held. Throughput: one sample word per cycle while
// intake is not stalled; the mode/timer update is one pass of combinational logic into the state registers.
// A two-entry output (result register plus skid register) keeps intake open while
// a result waits; intake stalls only when both entries are full.
// Reset (rst, synchronous): mode starting, counters cleared, config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_track_step_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // sample channel
  input  wire logic                              sample_valid,
  output      logic                              sample_stall,
  input  wire lst_pkg::sample_t                  sample,
  // result channel
  output      logic                              result_valid,
  input  wire logic                              result_stall,
  output      lst_pkg::result_t                  result,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [lst_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [7:0]                        cfg_data
);
  import lst_pkg::*;

  typedef enum logic [2:0] {
    MODE_STARTING,
    MODE_RUNNING,
    MODE_CORNER_L,
    MODE_CORNER_R,
    MODE_STOPPED
  } mode_t;

  // configuration
  logic [7:0] cross_target;
  logic [7:0] lost_limit;
  logic [5:0] cross_gap;

  // tracking state
  mode_t             mode, mode_next;
  logic signed [3:0] bearing_value, bearing_value_next;
  logic [4:0]        edge_pattern, edge_pattern_next;
  logic [5:0]        gap_timer, gap_timer_next;
  logic [7:0]        cross_total, cross_total_next;
  logic              cross_armed, cross_armed_next;
  logic [7:0]        lost_timer, lost_timer_next;

  // output buffering
  logic    skid_valid;
  result_t skid;
  result_t res_next;

  logic accept;
  logic take_free;
  logic stop;

  // intermediate values of a running tick
  logic [5:0] gap_inc;
  logic [7:0] lost_inc;
  logic [7:0] total_inc;
  logic [4:0] edge_upd;

  assign cfg_ready    = 1'b1;
  assign sample_stall = skid_valid;
  assign accept       = sample_valid && !sample_stall;
  // result register can load this cycle
  assign take_free    = !result_valid || !result_stall;

  always_comb begin
    gap_inc   = (gap_timer < cross_gap) ? gap_timer + 6'd1 : cross_gap;
    lost_inc  = (lost_timer == COUNT_MAX) ? COUNT_MAX : lost_timer + 8'd1;
    total_inc = (cross_total == COUNT_MAX) ? COUNT_MAX : cross_total + 8'd1;
    edge_upd  = ((sample.sensors & SENS_OUTER_MASK) != SENS_NONE) ? sample.sensors
                                                                  : edge_pattern;

    mode_next          = mode;
    bearing_value_next = bearing_value;
    edge_pattern_next  = edge_pattern;
    gap_timer_next     = gap_timer;
    cross_total_next   = cross_total;
    cross_armed_next   = cross_armed;
    lost_timer_next    = lost_timer;
    stop               = 1'b0;

    if (sample.command == CMD_RESTART) begin
      mode_next         = MODE_STARTING;
      cross_total_next  = '0;
      cross_armed_next  = 1'b1;
      gap_timer_next    = '0;
      edge_pattern_next = SENS_MIDDLE;
    end else begin
      case (mode)
        MODE_STARTING: begin
          mode_next = MODE_RUNNING;
        end
        MODE_RUNNING: begin
          gap_timer_next    = gap_inc;
          edge_pattern_next = edge_upd;
          if (sample.sensors != SENS_NONE) begin
            lost_timer_next = '0;
          end
          case (sample.sensors)
            SENS_NONE: begin
              // line lost: corner if an outer sensor saw it last
              if ((edge_upd & SENS_OUTER_LEFT) != SENS_NONE) begin
                mode_next = MODE_CORNER_L;
              end else if ((edge_upd & SENS_OUTER_RIGHT) != SENS_NONE) begin
                mode_next = MODE_CORNER_R;
              end else if (lost_inc >= lost_limit) begin
                lost_timer_next = '0;
                stop            = 1'b1;
              end else begin
                lost_timer_next = lost_inc;
              end
            end
            PAT_CENTER:     bearing_value_next = 4'sd0;
            PAT_MID_LEFT:   bearing_value_next = -4'sd1;
            PAT_MID_RIGHT:  bearing_value_next = 4'sd1;
            PAT_LEFT:       bearing_value_next = -4'sd2;
            PAT_RIGHT:      bearing_value_next = 4'sd2;
            PAT_WIDE_LEFT:  bearing_value_next = -4'sd4;
            PAT_WIDE_RIGHT: bearing_value_next = 4'sd4;
            PAT_EDGE_LEFT:  bearing_value_next = -4'sd7;
            PAT_EDGE_RIGHT: bearing_value_next = 4'sd7;
            SENS_ALL: begin
              // first crossing after restart skips gap and target checks
              if (cross_armed) begin
                cross_total_next = total_inc;
                cross_armed_next = 1'b0;
                gap_timer_next   = '0;
              end else if (gap_inc >= cross_gap) begin
                gap_timer_next   = '0;
                cross_total_next = total_inc;
                if (total_inc >= cross_target) begin
                  stop = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          if (stop) begin
            mode_next = MODE_STOPPED;
          end
        end
        MODE_CORNER_L, MODE_CORNER_R: begin
          if (sample.sensors != SENS_NONE) begin
            mode_next = MODE_RUNNING;
          end
        end
        default: begin
        end
      endcase
    end

    res_next.bearing        = bearing_value_next;
    res_next.turn_request   = (mode_next == MODE_CORNER_L) ? TURN_LEFT  :
                              (mode_next == MODE_CORNER_R) ? TURN_RIGHT : TURN_NONE;
    res_next.running        = (mode_next == MODE_RUNNING) || (mode_next == MODE_CORNER_L) ||
                              (mode_next == MODE_CORNER_R);
    res_next.stop_event     = stop;
    res_next.crossings_seen = cross_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cross_target  <= CROSS_TARGET_RST;
      lost_limit    <= LOST_LIMIT_RST;
      cross_gap     <= CROSS_GAP_RST;
      mode          <= MODE_STARTING;
      bearing_value <= '0;
      edge_pattern  <= '0;
      gap_timer     <= '0;
      cross_total   <= '0;
      cross_armed   <= 1'b1;
      lost_timer    <= '0;
      result_valid  <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CROSS_TARGET: cross_target <= cfg_data;
          REG_LOST_LIMIT:   lost_limit   <= cfg_data;
          REG_CROSS_GAP:    cross_gap    <= cfg_data[5:0];
          default: begin
          end
        endcase
      end

      if (accept) begin
        mode          <= mode_next;
        bearing_value <= bearing_value_next;
        edge_pattern  <= edge_pattern_next;
        gap_timer     <= gap_timer_next;
        cross_total   <= cross_total_next;
        cross_armed   <= cross_armed_next;
        lost_timer    <= lost_timer_next;
      end

      if (take_free) begin
        // skid word goes first to keep order; no intake while skid is full
        if (skid_valid) begin
          result       <= skid;
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end else if (accept) begin
          result       <= res_next;
          result_valid <= 1'b1;
        end else begin
          result_valid <= 1'b0;
        end
      end else if (accept) begin
        skid       <= res_next;
        skid_valid <= 1'b1;
      end
    end
  end

  // skid entry only fills behind a held result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid word present without a result word");

  // a stop always leaves tracking inactive
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.stop_event) |-> !result.running)
    else $error("stop word still shows running");

  // a corner turn is only reported while running
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.turn_request != TURN_NONE) |-> result.running)
    else $error("turn request while not running");

  // an accepted restart puts the block back into starting
  assert property (@(posedge clk) disable iff (rst)
    (accept && sample.command == CMD_RESTART) |=> (mode == MODE_STARTING))
    else $error("restart did not reach starting mode");

endmodule : line_sensor_track_step_core

`default_nettype wire

[bench/line_sensor_track_step_checker.sv]
// Checker for line_sensor_track_step_core: watches the sample, result and config
// channels, predicts each result word and compares it. Depends on lst_pkg.
`timescale 1ns / 1ps

module line_sensor_track_step_checker
  import lst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  input  logic                   sample_stall,
  input  sample_t                sample,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     worked
);

  typedef enum logic [2:0] {
    TRK_STARTING,
    TRK_RUNNING,
    TRK_CORNER_L,
    TRK_CORNER_R,
    TRK_STOPPED
  } trk_mode_e;

  // tracker copy of the config
  logic [7:0] cross_target;
  logic [7:0] lost_limit;
  logic [5:0] cross_gap;

  // tracker copy of the state
  trk_mode_e         mode;
  logic signed [3:0] bearing_value;
  logic [4:0]        edge_pattern;
  logic [5:0]        gap_timer;
  logic [7:0]        cross_total;
  logic              cross_armed;
  logic [7:0]        lost_timer;

  result_t expected_words[$];
  int      err_cnt = 0;
  int      work_cnt = 0;
  int      word_no = 0;

  function automatic logic [7:0] sat_inc8(logic [7:0] v);
    return (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

  task automatic flag_mismatch(string msg);
    if (err_cnt < 40)
      $display("ERROR @%0t result word %0d: %s", $realtime, word_no, msg);
    err_cnt++;
  endtask

  task automatic predict_word(sample_t w);
    result_t    r;
    logic       stop;
    logic [4:0] s;
    stop = 1'b0;
    s = w.sensors;
    work_cnt++;
    if (w.command == CMD_RESTART) begin
      // bearing and lost timer survive a restart
      mode = TRK_STARTING;
      cross_total = '0;
      cross_armed = 1'b1;
      gap_timer = '0;
      edge_pattern = SENS_MIDDLE;
    end else begin
      case (mode)
        TRK_STARTING: mode = TRK_RUNNING;
        TRK_RUNNING: begin
          if (gap_timer < cross_gap)
            gap_timer = gap_timer + 6'd1;
          else
            gap_timer = cross_gap;
          if (s != SENS_NONE)
            lost_timer = '0;
          if ((s & SENS_OUTER_MASK) != SENS_NONE)
            edge_pattern = s;
          case (s)
            SENS_NONE: begin
              if ((edge_pattern & SENS_OUTER_LEFT) != SENS_NONE) begin
                mode = TRK_CORNER_L;
              end else if ((edge_pattern & SENS_OUTER_RIGHT) != SENS_NONE) begin
                mode = TRK_CORNER_R;
              end else begin
                lost_timer = sat_inc8(lost_timer);
                if (lost_timer >= lost_limit) begin
                  lost_timer = '0;
                  stop = 1'b1;
                end
              end
            end
            PAT_CENTER:     bearing_value = 4'sd0;
            PAT_MID_LEFT:   bearing_value = -4'sd1;
            PAT_MID_RIGHT:  bearing_value = 4'sd1;
            PAT_LEFT:       bearing_value = -4'sd2;
            PAT_RIGHT:      bearing_value = 4'sd2;
            PAT_WIDE_LEFT:  bearing_value = -4'sd4;
            PAT_WIDE_RIGHT: bearing_value = 4'sd4;
            PAT_EDGE_LEFT:  bearing_value = -4'sd7;
            PAT_EDGE_RIGHT: bearing_value = 4'sd7;
            SENS_ALL: begin
              // first crossing after restart counts with no gap or target check
              if (cross_armed) begin
                cross_total = sat_inc8(cross_total);
                cross_armed = 1'b0;
                gap_timer = '0;
              end else if (gap_timer >= cross_gap) begin
                gap_timer = '0;
                cross_total = sat_inc8(cross_total);
                if (cross_total >= cross_target)
                  stop = 1'b1;
              end
            end
            default: ;
          endcase
          if (stop)
            mode = TRK_STOPPED;
        end
        TRK_CORNER_L, TRK_CORNER_R: begin
          if (s != SENS_NONE)
            mode = TRK_RUNNING;
        end
        default: ;
      endcase
    end
    r.bearing = bearing_value;
    r.turn_request = (mode == TRK_CORNER_L) ? TURN_LEFT :
                     (mode == TRK_CORNER_R) ? TURN_RIGHT : TURN_NONE;
    r.running = (mode == TRK_RUNNING || mode == TRK_CORNER_L || mode == TRK_CORNER_R);
    r.stop_event = stop;
    r.crossings_seen = cross_total;
    expected_words.push_back(r);
  endtask

  task automatic check_word(result_t got);
    result_t want;
    if (expected_words.size() == 0) begin
      flag_mismatch($sformatf("word arrived with nothing expected (%h)", got));
      word_no++;
      return;
    end
    want = expected_words.pop_front();
    if (got.bearing !== want.bearing)
      flag_mismatch($sformatf("bearing %0d, want %0d", got.bearing, want.bearing));
    if (got.turn_request !== want.turn_request)
      flag_mismatch($sformatf("turn_request %0d, want %0d",
                              got.turn_request, want.turn_request));
    if (got.running !== want.running)
      flag_mismatch($sformatf("running %b, want %b", got.running, want.running));
    if (got.stop_event !== want.stop_event)
      flag_mismatch($sformatf("stop_event %b, want %b", got.stop_event, want.stop_event));
    if (got.crossings_seen !== want.crossings_seen)
      flag_mismatch($sformatf("crossings_seen %0d, want %0d",
                              got.crossings_seen, want.crossings_seen));
    word_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cross_target = CROSS_TARGET_RST;
      lost_limit = LOST_LIMIT_RST;
      cross_gap = CROSS_GAP_RST;
      mode = TRK_STARTING;
      bearing_value = 4'sd0;
      edge_pattern = SENS_NONE;
      gap_timer = '0;
      cross_total = '0;
      cross_armed = 1'b1;
      lost_timer = '0;
      expected_words.delete();
    end else begin
      // the result is registered, so a word leaving now is never the one entering
      if (result_valid && !result_stall)
        check_word(result);
      // a word accepted at this edge still sees the old config
      if (sample_valid && !sample_stall)
        predict_word(sample);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CROSS_TARGET: cross_target = cfg_data;
          REG_LOST_LIMIT:   lost_limit = cfg_data;
          REG_CROSS_GAP:    cross_gap = cfg_data[5:0];
          default: ;
        endcase
      end
    end
    errors <= err_cnt;
    pending <= expected_words.size();
    worked <= work_cnt;
  end

endmodule

[bench/line_sensor_track_step_core_tb.sv]
// Testbench top for line_sensor_track_step_core: clock, reset, sample and config
// stimulus, random result stalls, verdict. Depends on lst_pkg and the checker.
`timescale 1ns / 1ps

module line_sensor_track_step_core_tb;
  import lst_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASES       = 8;

  logic                   clk;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_stall;
  sample_t                sample;
  logic                   result_valid;
  logic                   result_stall;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_data;

  int errors;
  int pending;
  int worked;
  bit steady;  // no random idling on either side while set

  // current settings, used only to shape the stimulus
  logic [7:0] cur_lost;
  logic [5:0] cur_gap;

  line_sensor_track_step_core u_top (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  line_sensor_track_step_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending),
    .worked      (worked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls plus long hold-offs that back the block up.
  initial begin
    int cyc;
    int hold;
    result_stall = 1'b0;
    cyc = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold == 0 && (cyc == 900 || (!steady && $urandom_range(0, 999) == 0)))
        hold = $urandom_range(40, 80);
      if (hold > 0) begin
        result_stall = 1'b1;
        hold--;
      end else begin
        result_stall = !steady && ($urandom_range(0, 99) < 18);
      end
    end
  end

  function automatic logic [4:0] rand_sensors(int unsigned lo);
    return 5'($urandom_range(lo, 31));
  endfunction

  function automatic sample_t tick_word(logic [4:0] s);
    sample_t w;
    w.command = CMD_TICK;
    w.sensors = s;
    return w;
  endfunction

  function automatic sample_t restart_word(logic [4:0] s);
    sample_t w;
    w.command = CMD_RESTART;
    w.sensors = s;
    return w;
  endfunction

  function automatic logic [4:0] inner_pattern();
    logic [4:0] pats [7];
    pats = '{PAT_CENTER, PAT_MID_LEFT, PAT_MID_RIGHT, PAT_LEFT, PAT_RIGHT, 5'h0A, 5'h0E};
    return pats[$urandom_range(0, 6)];
  endfunction

  function automatic logic [4:0] outer_pattern();
    logic [4:0] pats [4];
    logic [4:0] s;
    pats = '{PAT_EDGE_LEFT, PAT_EDGE_RIGHT, PAT_WIDE_LEFT, PAT_WIDE_RIGHT};
    if ($urandom_range(0, 9) < 6)
      return pats[$urandom_range(0, 3)];
    s = rand_sensors(0);
    return s | ($urandom_range(0, 1) ? SENS_OUTER_LEFT : SENS_OUTER_RIGHT);
  endfunction

  task automatic send_word(input sample_t w);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 18) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    sample = w;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] target, input logic [7:0] lost,
                            input logic [5:0] gap);
    cur_lost = lost;
    cur_gap = gap;
    write_reg(REG_CROSS_TARGET, target);
    write_reg(REG_LOST_LIMIT, lost);
    write_reg(REG_CROSS_GAP, {2'b00, gap});
  endtask

  // Drop valid, wait for every expected word, then a short pause for latency.
  task automatic settle();
    @(negedge clk);
    sample_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_segment();
    int kind;
    int n;
    sample_t w;
    kind = $urandom_range(0, 99);
    if (kind < 14) begin
      send_word(restart_word(rand_sensors(0)));
      send_word(tick_word(rand_sensors(0)));
    end else if (kind < 44) begin
      repeat ($urandom_range(1, 8)) send_word(tick_word(inner_pattern()));
    end else if (kind < 58) begin
      // corner: outer sensor, line lost, line found again
      send_word(tick_word(outer_pattern()));
      repeat ($urandom_range(1, 3)) send_word(tick_word(SENS_NONE));
      send_word(tick_word(rand_sensors(1)));
    end else if (kind < 78) begin
      repeat ($urandom_range(1, 3)) begin
        send_word(tick_word(SENS_ALL));
        n = int'(cur_gap) + int'($urandom_range(0, 2)) - 1;
        repeat (n < 0 ? 0 : n) send_word(tick_word(inner_pattern()));
      end
    end else if (kind < 90) begin
      // lost line needs a clean edge pattern, so start from a restart
      send_word(restart_word(rand_sensors(0)));
      send_word(tick_word(rand_sensors(0)));
      send_word(tick_word(inner_pattern()));
      n = int'(cur_lost) + int'($urandom_range(0, 2)) - 1;
      repeat (n < 1 ? 1 : n) send_word(tick_word(SENS_NONE));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        w.command = ($urandom_range(0, 7) == 0) ? CMD_RESTART : CMD_TICK;
        w.sensors = rand_sensors(0);
        send_word(w);
      end
    end
  endtask

  initial begin
    int ph;
    int base;
    int guard;
    rst = 1'b1;
    steady = 1'b0;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CROSS_TARGET;
    cfg_data = '0;
    cur_lost = LOST_LIMIT_RST;
    cur_gap = CROSS_GAP_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset settings: start, bearing table, unknown pattern, crossings, corners
    send_word(tick_word(SENS_ALL));
    send_word(tick_word(PAT_CENTER));
    send_word(tick_word(PAT_MID_LEFT));
    send_word(tick_word(PAT_MID_RIGHT));
    send_word(tick_word(PAT_LEFT));
    send_word(tick_word(PAT_RIGHT));
    send_word(tick_word(PAT_WIDE_LEFT));
    send_word(tick_word(PAT_WIDE_RIGHT));
    send_word(tick_word(PAT_EDGE_LEFT));
    send_word(tick_word(PAT_EDGE_RIGHT));
    send_word(tick_word(5'h0A));
    send_word(tick_word(SENS_ALL));
    send_word(tick_word(SENS_ALL));
    send_word(tick_word(SENS_NONE));
    send_word(tick_word(PAT_CENTER));
    send_word(tick_word(PAT_EDGE_LEFT));
    send_word(tick_word(SENS_NONE));
    send_word(tick_word(PAT_RIGHT));
    send_word(restart_word(SENS_ALL));
    send_word(tick_word(SENS_NONE));
    settle();

    // zero lost limit stops at once; zero gap and target stop on the second crossing
    set_config(8'd0, 8'd0, 6'd0);
    send_word(restart_word(SENS_NONE));
    send_word(tick_word(PAT_CENTER));
    send_word(tick_word(SENS_NONE));
    send_word(tick_word(SENS_ALL));
    send_word(restart_word(SENS_MIDDLE));
    send_word(tick_word(SENS_NONE));
    send_word(tick_word(SENS_ALL));
    send_word(tick_word(SENS_ALL));

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: set_config(8'd255, 8'd255, 6'd63);
        1: set_config(8'd0, 8'd0, 6'd0);
        2: set_config(8'd1, 8'd1, 6'd1);
        3: set_config(8'd255, 8'd50, 6'd0);
        4: set_config(CROSS_TARGET_RST, LOST_LIMIT_RST, CROSS_GAP_RST);
        7: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)));
        default: set_config(8'($urandom_range(0, 6)), 8'($urandom_range(0, 12)),
                            6'($urandom_range(0, 8)));
      endcase
      steady = (ph == 5);
      send_word(restart_word(rand_sensors(0)));
      if (ph == 3) begin
        // back-to-back crossings drive the count to its top
        send_word(tick_word(PAT_CENTER));
        repeat (260) send_word(tick_word(SENS_ALL));
      end
      base = worked;
      while (worked - base < RANDOM_ITEMS / PHASES) run_segment();
    end
    steady = 1'b0;

    @(negedge clk);
    sample_valid = 1'b0;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[line_sensor_track_step_core.f]
rtl/lst_pkg.sv
rtl/line_sensor_track_step_core.sv
bench/line_sensor_track_step_checker.sv
bench/line_sensor_track_step_core_tb.sv
